// ===== hw/rtl/tpm_pkg.sv =====
`default_nettype none

package tpm_pkg;

    // Field and counter widths
    localparam int INTERVAL_BITS = 17;
    localparam int FACTOR_BITS   = 4;
    localparam int WIDTH_BITS    = 10;
    localparam int MAX_FACTOR    = 9;
    localparam int DIV_CNT_BITS  = $clog2(INTERVAL_BITS + 1);

    typedef logic [INTERVAL_BITS-1:0] interval_t;
    typedef logic [FACTOR_BITS-1:0]   factor_t;
    typedef logic [WIDTH_BITS-1:0]    pwidth_t;

    localparam interval_t TIME_MAX   = {INTERVAL_BITS{1'b1}};
    localparam factor_t   FACTOR_CAP = FACTOR_BITS'(MAX_FACTOR);

    // Register reset values
    localparam factor_t   FACTOR_RESET       = FACTOR_BITS'(2);
    localparam interval_t MIN_INTERVAL_RESET = INTERVAL_BITS'(1000);
    localparam interval_t MAX_INTERVAL_RESET = INTERVAL_BITS'(100000);
    localparam pwidth_t   PULSE_LEN_RESET    = WIDTH_BITS'(100);

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_FACTOR       = 2'd0;
    localparam logic [1:0] REG_MIN_INTERVAL = 2'd1;
    localparam logic [1:0] REG_MAX_INTERVAL = 2'd2;
    localparam logic [1:0] REG_PULSE_LEN    = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        factor_t   factor;
        interval_t min_interval;
        interval_t max_interval;
        pwidth_t   width_ticks;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic tick_load;
        logic div_start;
        logic div_load;
        logic step;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tpm_divider.sv =====
`default_nettype none

module tpm_divider
    import tpm_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      start,
    input  wire interval_t dividend,
    input  wire factor_t   divisor,
    output logic           done,
    output interval_t      quotient
);

    interval_t                quo_reg, quo_next;
    factor_t                  rem_reg, rem_next;
    factor_t                  dsr_reg;
    logic [DIV_CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [FACTOR_BITS:0]     trial;
    logic                     ge;

    // One quotient bit per cycle, restoring
    always_comb begin
        trial    = {rem_reg, quo_reg[INTERVAL_BITS-1]};
        ge       = trial >= {1'b0, dsr_reg};
        rem_next = ge ? FACTOR_BITS'(trial - {1'b0, dsr_reg}) : trial[FACTOR_BITS-1:0];
        quo_next = {quo_reg[INTERVAL_BITS-2:0], ge};
        cnt_next = cnt_reg - 1'b1;
        busy_next = busy_reg && (cnt_reg != DIV_CNT_BITS'(1));
        done_next = busy_reg && (cnt_reg == DIV_CNT_BITS'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_BITS'(INTERVAL_BITS);
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            if (busy_reg) begin
                cnt_reg <= cnt_next;
            end
        end
    end

    // Operand and partial result words
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tpm_datapath.sv =====
`default_nettype none

module tpm_datapath
    import tpm_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cfg_t cfg,
    input  wire cmd_t cmd,
    output stat_t     stat,
    input  wire logic edge_seen,
    output logic      out_valid,
    input  wire logic out_ready,
    output logic      pulse_level,
    output logic      train_busy
);

    interval_t tsa_reg;
    logic      held_flag_reg;
    interval_t held_int_reg;
    interval_t held_age_reg;
    factor_t   pulses_reg, pulses_next;
    interval_t phase_reg, phase_next;
    interval_t gap_reg;
    logic      high_reg, high_next;
    logic      out_valid_reg;
    logic      level_reg, level_next;
    logic      busy_reg, busy_next;

    interval_t tsa_inc, age_inc, int1, age1, capped, width_ext, share, gap_calc, ph;
    logic      flag1, take, accepted;
    factor_t   fac_cap;
    pwidth_t   width_now;
    logic      div_done;

    // Tick front end: time counters, held edge and acceptance test
    always_comb begin
        tsa_inc  = (tsa_reg == TIME_MAX) ? tsa_reg : tsa_reg + 1'b1;
        age_inc  = held_flag_reg ? ((held_age_reg == TIME_MAX) ? held_age_reg
                                                               : held_age_reg + 1'b1)
                                 : held_age_reg;
        flag1    = held_flag_reg || edge_seen;
        int1     = edge_seen ? tsa_inc : held_int_reg;
        age1     = edge_seen ? '0 : age_inc;
        take     = (pulses_reg == '0) && flag1;
        accepted = take && (int1 >= cfg.min_interval);
        capped   = (int1 > cfg.max_interval) ? cfg.max_interval : int1;
        fac_cap  = (cfg.factor > FACTOR_CAP) ? FACTOR_CAP : cfg.factor;
        width_now = (cfg.width_ticks == '0) ? WIDTH_BITS'(1) : cfg.width_ticks;
        width_ext = INTERVAL_BITS'(width_now);
    end

    tpm_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (capped),
        .divisor  (fac_cap),
        .done     (div_done),
        .quotient (share)
    );

    assign gap_calc = (share > width_ext) ? share - width_ext : '0;

    // Train step for one tick
    always_comb begin
        pulses_next = pulses_reg;
        phase_next  = phase_reg;
        high_next   = high_reg;
        level_next  = 1'b0;
        busy_next   = 1'b0;
        ph          = (phase_reg == '0) ? INTERVAL_BITS'(1) : phase_reg;
        if (pulses_reg != '0) begin
            busy_next = 1'b1;
            ph        = ph - 1'b1;
            phase_next = ph;
            if (high_reg) begin
                level_next = 1'b1;
                if (ph == '0) begin
                    pulses_next = pulses_reg - 1'b1;
                    if (pulses_reg == FACTOR_BITS'(1)) begin
                        high_next = 1'b0;
                    end else if (gap_reg != '0) begin
                        high_next  = 1'b0;
                        phase_next = gap_reg;
                    end else begin
                        phase_next = width_ext;
                    end
                end
            end else if (ph == '0) begin
                high_next  = 1'b1;
                phase_next = width_ext;
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tsa_reg       <= '0;
            held_flag_reg <= 1'b0;
            held_int_reg  <= '0;
            held_age_reg  <= '0;
            pulses_reg    <= '0;
            phase_reg     <= '0;
            gap_reg       <= '0;
            high_reg      <= 1'b0;
        end else begin
            if (cmd.tick_load) begin
                tsa_reg       <= accepted ? age1 : tsa_inc;
                held_flag_reg <= take ? 1'b0 : flag1;
                held_int_reg  <= int1;
                held_age_reg  <= age1;
            end
            if (cmd.div_load) begin
                gap_reg    <= gap_calc;
                pulses_reg <= fac_cap;
                high_reg   <= 1'b1;
                phase_reg  <= width_ext;
            end
            if (cmd.step) begin
                pulses_reg <= pulses_next;
                phase_reg  <= phase_next;
                high_reg   <= high_next;
            end
        end
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.step) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            level_reg <= level_next;
            busy_reg  <= busy_next;
        end
    end

    assign stat.need_div = accepted && (fac_cap != '0);
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign pulse_level   = level_reg;
    assign train_busy    = busy_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tpm_ctrl.sv =====
`default_nettype none

module tpm_ctrl
    import tpm_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequencer: take tick, divide if a train starts, then step and emit
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.tick_load = 1'b1;
                    if (stat.need_div) begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.step   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/trigger_pulse_multiplier.sv =====
`default_nettype none

// Trigger pulse multiplier. Each input word is one microsecond tick carrying
// a trigger edge flag; each tick gives exactly one output word with the pulse
// line level and a train-busy flag. An accepted edge starts a train of
// multiply_factor pulses spread over the capped interval since the previous
// accepted edge. A tick that starts no train is accepted, then stepped; a
// tick that starts a train is accepted, then waits for the bit-serial
// interval divider (one quotient bit per cycle), then is loaded and stepped.
// The next tick is taken once the current one has stepped;
// the output register lets that tick be taken while the sink holds a word,
// its step then waits for the sink. Registers
// sit on the APB port at 0x0 factor, 0x4 min interval, 0x8 max interval,
// 0xC pulse width, and should be written only while the block is idle.
module trigger_pulse_multiplier
    import tpm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input ticks
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] edge_seen
    // Output words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [0] pulse_level, [1] train_busy
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;
    logic  cfg_wr;
    logic  level, busy;

    // Register file
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.factor       <= FACTOR_RESET;
            cfg_reg.min_interval <= MIN_INTERVAL_RESET;
            cfg_reg.max_interval <= MAX_INTERVAL_RESET;
            cfg_reg.width_ticks  <= PULSE_LEN_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_FACTOR:       cfg_reg.factor       <= pwdata[FACTOR_BITS-1:0];
                REG_MIN_INTERVAL: cfg_reg.min_interval <= pwdata[INTERVAL_BITS-1:0];
                REG_MAX_INTERVAL: cfg_reg.max_interval <= pwdata[INTERVAL_BITS-1:0];
                REG_PULSE_LEN:    cfg_reg.width_ticks  <= pwdata[WIDTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[3:2])
            REG_FACTOR:       prdata = 32'(cfg_reg.factor);
            REG_MIN_INTERVAL: prdata = 32'(cfg_reg.min_interval);
            REG_MAX_INTERVAL: prdata = 32'(cfg_reg.max_interval);
            REG_PULSE_LEN:    prdata = 32'(cfg_reg.width_ticks);
            default:          prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    tpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tpm_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .stat        (stat),
        .edge_seen   (s_tdata[0]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .pulse_level (level),
        .train_busy  (busy)
    );

    assign m_tdata = {6'b0, busy, level};

endmodule

`default_nettype wire

// ===== tb/tb_trigger_pulse_multiplier.sv =====
`default_nettype none

module tb_trigger_pulse_multiplier
    import tpm_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES     = 40;
    localparam int DRAIN_LIMIT      = 20000;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int PHASE_TICKS      = 96;

    // One expected output word
    typedef struct packed {
        logic train_busy;
        logic pulse_level;
    } tick_out_t;

    // Predicts the pulse line per tick and checks the output words in order
    class pulse_scoreboard;
        factor_t   factor_reg;
        interval_t min_iv;
        interval_t max_iv;
        pwidth_t   width_reg;

        interval_t since_accept;
        logic      held_flag;
        interval_t held_iv;
        interval_t held_age;
        factor_t   pulses_left;
        interval_t phase_cnt;
        interval_t gap_cnt;
        logic      high_phase;

        tick_out_t expected_q[$];
        int        errors;

        function new();
            factor_reg   = FACTOR_RESET;
            min_iv       = MIN_INTERVAL_RESET;
            max_iv       = MAX_INTERVAL_RESET;
            width_reg    = PULSE_LEN_RESET;
            since_accept = '0;
            held_flag    = 1'b0;
            held_iv      = '0;
            held_age     = '0;
            pulses_left  = '0;
            phase_cnt    = '0;
            gap_cnt      = '0;
            high_phase   = 1'b0;
            errors       = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_FACTOR:       factor_reg = factor_t'(value);
                REG_MIN_INTERVAL: min_iv     = interval_t'(value);
                REG_MAX_INTERVAL: max_iv     = interval_t'(value);
                REG_PULSE_LEN:    width_reg  = pwidth_t'(value);
                default: ;
            endcase
        endfunction

        function interval_t sat_inc(interval_t v);
            return (v == TIME_MAX) ? v : v + 1'b1;
        endfunction

        // zero width behaves as one tick
        function pwidth_t eff_width();
            return (width_reg == '0) ? pwidth_t'(1) : width_reg;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the predicted state by one accepted tick
        function void note_tick(logic edge_bit);
            tick_out_t exp_word;
            factor_t   f;
            interval_t iv;
            interval_t share;
            pwidth_t   w;
            exp_word = '0;

            since_accept = sat_inc(since_accept);
            if (held_flag)
                held_age = sat_inc(held_age);

            // latest edge replaces any held one
            if (edge_bit) begin
                held_flag = 1'b1;
                held_iv   = since_accept;
                held_age  = '0;
            end

            // take the held edge once no train runs
            if (pulses_left == '0 && held_flag) begin
                held_flag = 1'b0;
                f  = (factor_reg > FACTOR_CAP) ? FACTOR_CAP : factor_reg;
                iv = held_iv;
                if (iv >= min_iv) begin
                    since_accept = held_age;
                    if (iv > max_iv)
                        iv = max_iv;
                    if (f != '0) begin
                        w           = eff_width();
                        share       = iv / f;
                        gap_cnt     = (share > w) ? share - w : '0;
                        pulses_left = f;
                        high_phase  = 1'b1;
                        phase_cnt   = interval_t'(w);
                    end
                end
            end

            // train output and progress
            if (pulses_left != '0) begin
                exp_word.train_busy = 1'b1;
                if (phase_cnt == '0)
                    phase_cnt = interval_t'(1);
                if (high_phase) begin
                    exp_word.pulse_level = 1'b1;
                    phase_cnt--;
                    if (phase_cnt == '0) begin
                        pulses_left--;
                        if (pulses_left == '0) begin
                            high_phase = 1'b0;
                        end else if (gap_cnt != '0) begin
                            high_phase = 1'b0;
                            phase_cnt  = gap_cnt;
                        end else begin
                            phase_cnt = interval_t'(eff_width());
                        end
                    end
                end else begin
                    phase_cnt--;
                    if (phase_cnt == '0) begin
                        high_phase = 1'b1;
                        phase_cnt  = interval_t'(eff_width());
                    end
                end
            end

            expected_q.push_back(exp_word);
        endfunction

        task report_mismatch(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_word(logic [7:0] word);
            tick_out_t exp_word;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("output word 0x%02h with nothing expected", word));
            end else begin
                exp_word = expected_q.pop_front();
                if (word[0] !== exp_word.pulse_level)
                    report_mismatch($sformatf("pulse_level %b, expected %b",
                                              word[0], exp_word.pulse_level));
                if (word[1] !== exp_word.train_busy)
                    report_mismatch($sformatf("train_busy %b, expected %b",
                                              word[1], exp_word.train_busy));
            end
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [0] edge_seen
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [0] pulse_level, [1] train_busy
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int   src_idle_pct  = 0;
    int   sink_idle_pct = 0;
    logic sink_hold_req = 1'b0;

    pulse_scoreboard sb;

    trigger_pulse_multiplier i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 aclk = ~aclk;

    // Watch both channels at each edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_tick(s_tdata[0]);
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata);
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_left == 0 && sink_hold_req) begin
                hold_left     = SINK_HOLD_CYCLES;
                sink_hold_req = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    initial begin
        #15ms;
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_tick(input logic edge_bit);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, edge_bit};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Send n ticks, edge flags taken from mask LSB first
    task automatic send_pattern(input logic [31:0] mask, input int n);
        for (int i = 0; i < n; i++)
            send_tick(mask[i]);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        @(posedge aclk);
        while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Stop sending, let the block drain, then write all four registers
    task automatic load_config(input factor_t f, input interval_t mn,
                               input interval_t mx, input pwidth_t w);
        s_tvalid <= 1'b0;
        wait_drained();
        apb_write(REG_FACTOR,       32'(f));
        apb_write(REG_MIN_INTERVAL, 32'(mn));
        apb_write(REG_MAX_INTERVAL, 32'(mx));
        apb_write(REG_PULSE_LEN,    32'(w));
    endtask

    // Random settings, mostly short intervals so trains start often
    task automatic random_phase();
        factor_t   f;
        interval_t mn;
        interval_t mx;
        pwidth_t   w;
        int        edge_pct;
        f  = ($urandom_range(7) == 0) ? factor_t'($urandom_range(15))
                                      : factor_t'($urandom_range(MAX_FACTOR, 1));
        mn = ($urandom_range(7) == 0) ? interval_t'($urandom) : interval_t'($urandom_range(40));
        mx = ($urandom_range(7) == 0) ? interval_t'($urandom)
                                      : interval_t'($urandom_range(150, 1));
        w  = ($urandom_range(7) == 0) ? pwidth_t'($urandom_range(1000))
                                      : pwidth_t'($urandom_range(12, 1));
        edge_pct = $urandom_range(40, 3);
        load_config(f, mn, mx, w);
        repeat (PHASE_TICKS)
            send_tick($urandom_range(99) < edge_pct);
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // noise edge, accepted edge, then edges held during the train
        load_config(factor_t'(3), interval_t'(2), interval_t'(60), pwidth_t'(2));
        send_pattern(32'h0000_1A01, 18);
        // factor zero: edge accepted, no pulses
        load_config(factor_t'(0), interval_t'(0), interval_t'(60), pwidth_t'(2));
        send_pattern(32'h0000_0004, 6);
        // factor above cap, zero width, capped interval so pulses merge
        load_config(factor_t'(15), interval_t'(0), interval_t'(1), pwidth_t'(0));
        send_pattern(32'h0000_0005, 4);

        // random part in three idling regimes
        for (int regime = 0; regime < 3; regime++) begin
            case (regime)
                0: begin src_idle_pct = 28; sink_idle_pct = 46; end
                1: begin src_idle_pct = 46; sink_idle_pct = 28; end
                default: begin src_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            for (int ph = 0; ph < 4; ph++) begin
                if (regime == 0 && ph == 1)
                    sink_hold_req = 1'b1;
                random_phase();
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected words never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
